FILE: rtl/hrl_pkg.sv
`default_nettype none

package hrl_pkg;

  localparam int unsigned AddrWidth = 16;
  localparam int unsigned CharWidth = 8;
  localparam int unsigned DataWidth = 8;

  localparam logic [CharWidth-1:0] RecordMark = 8'h3A;
  localparam logic [7:0]           DataRecordType = 8'h00;

  typedef struct packed {
    logic                 valid;
    logic [AddrWidth-1:0] address;
    logic [DataWidth-1:0] data;
  } wr_beat_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
  } hex_digit_t;

  function automatic hex_digit_t hex_decode(input logic [CharWidth-1:0] c);
    hex_digit_t r;
    logic [CharWidth-1:0] off;
    r   = '0;
    off = '0;
    if (c inside {[8'h30:8'h39]}) begin
      off      = c - 8'h30;
      r.is_hex = 1'b1;
      r.nibble = off[3:0];
    end else if (c inside {[8'h41:8'h46]}) begin
      off      = c - 8'h37;
      r.is_hex = 1'b1;
      r.nibble = off[3:0];
    end else if (c inside {[8'h61:8'h66]}) begin
      off      = c - 8'h57;
      r.is_hex = 1'b1;
      r.nibble = off[3:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/hrl_char_if.sv
`default_nettype none

interface hrl_char_if;
  logic                           valid;
  logic                           ready;
  logic [hrl_pkg::CharWidth-1:0]  char_in;

  modport source (output valid, output char_in, input ready);
  modport sink   (input valid, input char_in, output ready);
endinterface

`default_nettype wire

FILE: rtl/hrl_wr_if.sv
`default_nettype none

interface hrl_wr_if;
  logic                           valid;
  logic                           ready;
  logic [hrl_pkg::AddrWidth-1:0]  write_address;
  logic [hrl_pkg::DataWidth-1:0]  write_data;

  modport source (output valid, output write_address, output write_data, input ready);
  modport sink   (input valid, input write_address, input write_data, output ready);
endinterface

`default_nettype wire

FILE: rtl/hrl_decoder.sv
`default_nettype none

module hrl_decoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          fire_i,
  input  wire logic [hrl_pkg::CharWidth-1:0] char_i,
  output hrl_pkg::wr_beat_t                  beat_o
);

  localparam logic [2:0] PhIdle  = 3'd0;
  localparam logic [2:0] PhCount = 3'd1;
  localparam logic [2:0] PhAddr  = 3'd2;
  localparam logic [2:0] PhType  = 3'd3;
  localparam logic [2:0] PhData  = 3'd4;
  localparam logic [2:0] PhSkip  = 3'd5;

  logic [2:0]                   phase_q, phase_d;
  logic [2:0]                   dcnt_q, dcnt_d;
  logic [7:0]                   bcnt_q, bcnt_d;
  logic [hrl_pkg::AddrWidth-1:0] base_q, base_d;
  logic [7:0]                   rtype_q, rtype_d;
  logic [7:0]                   bidx_q, bidx_d;
  logic [3:0]                   hnib_q, hnib_d;
  logic [8:0]                   bidx_inc;
  hrl_pkg::hex_digit_t          hd;

  assign hd       = hrl_pkg::hex_decode(char_i);
  assign bidx_inc = {1'b0, bidx_q} + 9'd1;

  always_comb begin
    phase_d = phase_q;
    dcnt_d  = dcnt_q;
    bcnt_d  = bcnt_q;
    base_d  = base_q;
    rtype_d = rtype_q;
    bidx_d  = bidx_q;
    hnib_d  = hnib_q;
    beat_o  = '0;
    if (fire_i) begin
      if (char_i == hrl_pkg::RecordMark) begin
        phase_d = PhCount;
        dcnt_d  = '0;
        bcnt_d  = '0;
        base_d  = '0;
        rtype_d = '0;
        bidx_d  = '0;
        hnib_d  = '0;
      end else if (!hd.is_hex) begin
        phase_d = PhIdle;
        dcnt_d  = '0;
      end else begin
        case (phase_q)
          PhCount: begin
            bcnt_d = {bcnt_q[3:0], hd.nibble};
            dcnt_d = dcnt_q + 3'd1;
            if (dcnt_q == 3'd1) begin
              phase_d = PhAddr;
              dcnt_d  = '0;
            end
          end
          PhAddr: begin
            base_d = {base_q[hrl_pkg::AddrWidth-5:0], hd.nibble};
            dcnt_d = dcnt_q + 3'd1;
            if (dcnt_q == 3'd3) begin
              phase_d = PhType;
              dcnt_d  = '0;
            end
          end
          PhType: begin
            rtype_d = {rtype_q[3:0], hd.nibble};
            dcnt_d  = dcnt_q + 3'd1;
            if (dcnt_q == 3'd1) begin
              dcnt_d  = '0;
              bidx_d  = '0;
              phase_d = (rtype_d == hrl_pkg::DataRecordType && bcnt_q != 8'd0) ?
                        PhData : PhSkip;
            end
          end
          PhData: begin
            if (dcnt_q == 3'd0) begin
              hnib_d = hd.nibble;
              dcnt_d = 3'd1;
            end else begin
              beat_o.valid   = 1'b1;
              beat_o.address = base_q + {{(hrl_pkg::AddrWidth-8){1'b0}}, bidx_q};
              beat_o.data    = {hnib_q, hd.nibble};
              dcnt_d         = '0;
              bidx_d         = bidx_inc[7:0];
              if (bidx_inc >= {1'b0, bcnt_q}) begin
                phase_d = PhSkip;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      dcnt_q  <= '0;
      bcnt_q  <= '0;
      base_q  <= '0;
      rtype_q <= '0;
      bidx_q  <= '0;
      hnib_q  <= '0;
    end else begin
      phase_q <= phase_d;
      dcnt_q  <= dcnt_d;
      bcnt_q  <= bcnt_d;
      base_q  <= base_d;
      rtype_q <= rtype_d;
      bidx_q  <= bidx_d;
      hnib_q  <= hnib_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hex_record_loader_unit.sv
// Hex record loader: turns a text stream of hex records into memory writes.
// rec_i carries one ASCII character per beat. wr_o carries one write beat
// (write_address, write_data) for each complete data byte pair of a type 00
// record; all other characters produce no beat.
// Path: a character taken on rec_i goes into the input register, through the
// decoder, and its write beat into the output register that drives wr_o.
// Throughput: one character per cycle while wr_o does not stall, set by the
// state update between the input register and the output register.
// Stalls: when wr_o is held not ready with a beat pending, the input
// register holds its character and rec_i.ready drops once that register is
// full; no beat is lost or repeated.
// Reset: rst_ni clears the valid flags of both registers and returns the
// parser to idle, waiting for a colon.
`default_nettype none

module hex_record_loader_unit (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hrl_char_if.sink  rec_i,
  hrl_wr_if.source  wr_o
);

  logic                          in_valid_q;
  logic [hrl_pkg::CharWidth-1:0] char_q;
  logic                          out_valid_q;
  logic [hrl_pkg::AddrWidth-1:0] addr_q;
  logic [hrl_pkg::DataWidth-1:0] data_q;
  logic                          advance;
  logic                          fire;
  hrl_pkg::wr_beat_t             beat;

  assign advance    = !out_valid_q || wr_o.ready;
  assign fire       = in_valid_q && advance;
  assign rec_i.ready = !in_valid_q || advance;

  hrl_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .char_i (char_q),
    .beat_o (beat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (rec_i.ready) begin
        in_valid_q <= rec_i.valid;
      end
      if (advance) begin
        out_valid_q <= fire && beat.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_i.ready && rec_i.valid) begin
      char_q <= rec_i.char_in;
    end
    if (fire && beat.valid) begin
      addr_q <= beat.address;
      data_q <= beat.data;
    end
  end

  assign wr_o.valid         = out_valid_q;
  assign wr_o.write_address = addr_q;
  assign wr_o.write_data    = data_q;

endmodule

`default_nettype wire

FILE: verif/tb_hex_record_loader_unit.sv
`timescale 1ns / 100ps

module tb_hex_record_loader_unit;

  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned RandomChars = 1500;

  typedef enum logic [2:0] {
    PS_IDLE, PS_COUNT, PS_ADDR, PS_TYPE, PS_DATA, PS_SKIP
  } parse_state_e;

  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_PERIODIC, RX_STARVE} rx_mode_e;

  typedef struct packed {
    logic [hrl_pkg::AddrWidth-1:0] address;
    logic [hrl_pkg::DataWidth-1:0] data;
  } mem_write_t;

  typedef struct packed {
    logic                          hold_for_drain;
    logic [hrl_pkg::CharWidth-1:0] ch;
  } text_char_t;

  logic                          clk      = 1'b0;
  logic                          rst_n    = 1'b0;
  logic                          ch_valid = 1'b0;
  logic [hrl_pkg::CharWidth-1:0] ch_data  = '0;
  logic                          wr_ready = 1'b0;

  hrl_char_if char_if ();
  hrl_wr_if   wr_if ();

  assign char_if.valid   = ch_valid;
  assign char_if.char_in = ch_data;
  assign wr_if.ready     = wr_ready;

  hex_record_loader_unit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .rec_i (char_if),
    .wr_o  (wr_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Record parser state
  parse_state_e                  ps_state  = PS_IDLE;
  logic [2:0]                    ps_digits = '0;
  logic [7:0]                    ps_count  = '0;
  logic [hrl_pkg::AddrWidth-1:0] ps_base   = '0;
  logic [7:0]                    ps_type   = '0;
  logic [7:0]                    ps_index  = '0;
  logic [3:0]                    ps_high   = '0;
  mem_write_t                    writes_due[$];

  text_char_t  pending[$];
  int unsigned chars_queued  = 0;
  int unsigned chars_taken   = 0;
  logic        char_taken    = 1'b0;
  int unsigned writes_seen   = 0;
  int unsigned wr_errors     = 0;
  int unsigned cycle_count   = 0;
  int unsigned burst_left    = 0;
  int unsigned gap_left      = 0;
  int unsigned holdoff_left  = 0;
  int unsigned holdoffs_done = 0;
  int unsigned mode_left     = 0;
  int unsigned rx_tick       = 0;
  rx_mode_e    stall_mode    = RX_OPEN;

  // bit 4 flags a hex digit
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    logic [7:0] d;
    d = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      d = c - 8'h30;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h41 && c <= 8'h46) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    if (c >= 8'h61 && c <= 8'h66) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end
    return 5'b0;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n, input logic upper);
    if (n < 4'd10) return 8'h30 + n;
    return upper ? 8'h37 + n : 8'h57 + n;
  endfunction

  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    logic [4:0] h;
    do begin
      c = 8'($urandom_range(0, 255));
      h = nibble_of(c);
    end while (h[4] || c == hrl_pkg::RecordMark);
    return c;
  endfunction

  task automatic parse_char(input logic [7:0] c);
    logic [4:0] h;
    mem_write_t w;
    h = nibble_of(c);
    if (c == hrl_pkg::RecordMark) begin
      ps_state  = PS_COUNT;
      ps_digits = '0;
      ps_count  = '0;
      ps_base   = '0;
      ps_type   = '0;
      ps_index  = '0;
      ps_high   = '0;
    end else if (!h[4]) begin
      ps_state  = PS_IDLE;
      ps_digits = '0;
    end else begin
      case (ps_state)
        PS_COUNT: begin
          ps_count  = {ps_count[3:0], h[3:0]};
          ps_digits = ps_digits + 3'd1;
          if (ps_digits == 3'd2) begin
            ps_state  = PS_ADDR;
            ps_digits = '0;
          end
        end
        PS_ADDR: begin
          ps_base   = {ps_base[hrl_pkg::AddrWidth-5:0], h[3:0]};
          ps_digits = ps_digits + 3'd1;
          if (ps_digits == 3'd4) begin
            ps_state  = PS_TYPE;
            ps_digits = '0;
          end
        end
        PS_TYPE: begin
          ps_type   = {ps_type[3:0], h[3:0]};
          ps_digits = ps_digits + 3'd1;
          if (ps_digits == 3'd2) begin
            ps_digits = '0;
            ps_index  = '0;
            ps_state  = (ps_type == hrl_pkg::DataRecordType && ps_count != 8'd0) ?
                        PS_DATA : PS_SKIP;
          end
        end
        PS_DATA: begin
          if (ps_digits == 3'd0) begin
            ps_high   = h[3:0];
            ps_digits = 3'd1;
          end else begin
            w.address = ps_base + {{(hrl_pkg::AddrWidth-8){1'b0}}, ps_index};
            w.data    = {ps_high, h[3:0]};
            writes_due.push_back(w);
            ps_digits = '0;
            ps_index  = ps_index + 8'd1;
            if (ps_index >= ps_count) ps_state = PS_SKIP;
          end
        end
        default: ;
      endcase
    end
  endtask

  task automatic push_char(input logic [7:0] c, input logic drain = 1'b0);
    text_char_t t;
    t.hold_for_drain = drain;
    t.ch             = c;
    pending.push_back(t);
    chars_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endtask

  task automatic push_hex(input logic [31:0] v, input int unsigned n);
    for (int i = n - 1; i >= 0; i--) push_char(hex_char(v[4*i +: 4], 1'($urandom_range(0, 1))));
  endtask

  task automatic push_record(input logic drain);
    int unsigned n;
    int unsigned digits;
    n = ($urandom_range(0, 39) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 16);
    push_char(hrl_pkg::RecordMark, drain);
    push_hex(n, 2);
    push_hex($urandom_range(0, 65535), 4);
    push_hex(($urandom_range(0, 6) == 0) ? $urandom_range(0, 255) : hrl_pkg::DataRecordType,
             2);
    digits = 2 * n + 2;
    case ($urandom_range(0, 9))
      0: digits = $urandom_range(0, digits);
      1: digits = digits + $urandom_range(1, 6);
      default: ;
    endcase
    for (int i = 0; i < digits; i++) push_hex($urandom_range(0, 15), 1);
    case ($urandom_range(0, 3))
      0: push_char(8'h0A);
      1: begin
        push_char(8'h0D);
        push_char(8'h0A);
      end
      2: push_char(non_hex_char());
      default: ;
    endcase
  endtask

  // Accept input beats and predict their writes
  always @(posedge clk) begin
    char_taken = ch_valid && char_if.ready;
    if (char_taken) begin
      parse_char(ch_data);
      chars_taken++;
    end
  end

  always @(posedge clk) begin
    mem_write_t got;
    mem_write_t want;
    if (rst_n && wr_if.valid && wr_ready) begin
      got.address = wr_if.write_address;
      got.data    = wr_if.write_data;
      writes_seen++;
      if (writes_due.size() == 0) begin
        wr_errors++;
        if (wr_errors <= 10)
          $display("unexpected write: address %h data %h", got.address, got.data);
      end else begin
        want = writes_due.pop_front();
        if (got.address !== want.address || got.data !== want.data) begin
          wr_errors++;
          if (wr_errors <= 10)
            $display("write mismatch: address exp %h got %h, data exp %h got %h",
                     want.address, got.address, want.data, got.data);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_hex_record_loader_unit: errors");
      $finish;
    end
  end

  // Sender: bursts with random gaps; hold a flagged beat until all writes drain
  always @(negedge clk) begin
    if (rst_n && !(ch_valid && !char_taken)) begin
      if (gap_left != 0) begin
        ch_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending.size() == 0 ||
                   (pending[0].hold_for_drain && writes_due.size() != 0)) begin
        ch_valid <= 1'b0;
      end else begin
        ch_valid <= 1'b1;
        ch_data  <= pending[0].ch;
        void'(pending.pop_front());
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 48);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Receiver: stall pattern by mode, plus long hold-offs with writes pending
  always @(negedge clk) begin
    if (!rst_n) begin
      wr_ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      wr_ready     <= 1'b0;
      holdoff_left <= holdoff_left - 1;
    end else if (holdoffs_done < 2 && writes_seen >= 60 * (holdoffs_done + 1) &&
                 writes_due.size() != 0) begin
      wr_ready      <= 1'b0;
      holdoff_left  <= 400;
      holdoffs_done <= holdoffs_done + 1;
    end else begin
      rx_tick <= rx_tick + 1;
      if (mode_left == 0) begin
        stall_mode <= rx_mode_e'($urandom_range(0, 3));
        mode_left  <= $urandom_range(20, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        RX_OPEN:     wr_ready <= 1'b1;
        RX_COIN:     wr_ready <= 1'($urandom_range(0, 1));
        RX_PERIODIC: wr_ready <= (rx_tick % 5) != 0;
        default:     wr_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  initial begin
    push_char(8'h00);
    push_char(8'hFF);
    push_text(":02FFFF00Fe019");
    push_text(":1:00000000G");
    push_text(":01ABCD0755\n");
    push_text(":02000a00123\n");

    push_record(1'b1);
    while (chars_queued < RandomChars) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) push_char(8'($urandom_range(0, 255)));
      end else begin
        push_record($urandom_range(0, 19) == 0);
      end
    end

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    while (chars_taken != chars_queued) @(negedge clk);
    while (writes_due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (wr_errors == 0 && writes_due.size() == 0) begin
      $display("tb_hex_record_loader_unit: clean");
    end else begin
      $display("tb_hex_record_loader_unit: errors");
    end
    $finish;
  end

endmodule

FILE: hex_record_loader_unit.f
rtl/hrl_pkg.sv
rtl/hrl_char_if.sv
rtl/hrl_wr_if.sv
rtl/hrl_decoder.sv
rtl/hex_record_loader_unit.sv
verif/tb_hex_record_loader_unit.sv
